// ===== rtl/srm_pkg.sv =====
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants for the segmentation region metrics block.
// ----------------------------------------------------------------------------
package srm_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CNT_W = 25;
    localparam int MET_W = 17;
    localparam int POS_W = 12;
    localparam int SQ_W  = 28;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_CENTER_X    = 3'd1;
    localparam logic [2:0] REG_CENTER_Y    = 3'd2;
    localparam logic [2:0] REG_CENTER_RSQ  = 3'd3;
    localparam logic [2:0] REG_EDGE_RSQ    = 3'd4;

    // region codes
    localparam logic [1:0] REGION_FULL   = 2'd0;
    localparam logic [1:0] REGION_CENTER = 2'd1;
    localparam logic [1:0] REGION_EDGE   = 2'd2;

    typedef struct packed {
        logic pred_bit;
        logic truth_bit;
        logic frame_end;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       region_id;
        logic [CNT_W-1:0] true_pos;
        logic [CNT_W-1:0] false_pos;
        logic [CNT_W-1:0] false_neg;
        logic [CNT_W-1:0] true_neg;
        logic [MET_W-1:0] iou_q16;
        logic [MET_W-1:0] precision_q16;
        logic [MET_W-1:0] recall_q16;
        logic [MET_W-1:0] f1_q16;
        logic             last_of_run;
    } out_beat_t;

    // classified pixel passed from front to back
    typedef struct packed {
        logic pred_bit;
        logic truth_bit;
        logic in_center;
        logic in_edge;
        logic frame_end;
    } pix_class_t;

    typedef struct packed {
        logic [CNT_W-1:0] tp;
        logic [CNT_W-1:0] fp;
        logic [CNT_W-1:0] fn;
        logic [CNT_W-1:0] tot;
    } region_cnt_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== rtl/srm_front.sv =====
// ----------------------------------------------------------------------------
// srm_front
// Tracks raster position and classes each pixel into center and edge regions.
// ----------------------------------------------------------------------------
module srm_front #(
    parameter int MAX_WIDTH  = srm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = srm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  srm_pkg::in_beat_t        s_data,
    input  logic [12:0]              frame_width,
    input  logic [12:0]              center_x_doubled,
    input  logic [12:0]              center_y_doubled,
    input  logic [srm_pkg::SQ_W-1:0] center_radius_sq,
    input  logic [srm_pkg::SQ_W-1:0] edge_radius_sq,
    output logic                     q_valid,
    input  logic                     q_ready,
    output srm_pkg::pix_class_t      q_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = XW + 1;
    localparam int DW = (XW > YW ? XW : YW) + 2;

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [WW-1:0] w_eff;
    logic [DW-1:0] dx, dy, x2, y2;
    logic [2*DW:0] dsq;
    logic          acc;

    // stage 1: difference registers
    logic [DW-1:0] dx_reg, dy_reg;
    logic          v1_reg;
    logic          p1_reg, t1_reg, e1_reg;
    // stage 2: squares
    logic [2*DW-1:0] sx_reg, sy_reg;
    logic            v2_reg;
    logic            p2_reg, t2_reg, e2_reg;
    logic            adv;

    assign adv     = !v2_reg || q_ready;
    assign s_ready = adv;
    assign acc     = s_valid && s_ready;

    // effective width clamped to 1..MAX_WIDTH
    always_comb begin
        if (frame_width == 13'd0) begin
            w_eff = WW'(1);
        end else if (32'(frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width);
        end
    end

    // position counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (s_data.frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if ((WW'(col_reg) + WW'(1)) >= w_eff) begin
                col_next = '0;
                row_next = (32'(row_reg) + 1 >= MAX_HEIGHT) ? '0 : row_reg + YW'(1);
            end else begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    assign x2 = DW'({col_reg, 1'b0});
    assign y2 = DW'({row_reg, 1'b0});
    always_comb begin
        dx = (x2 >= DW'(center_x_doubled)) ? x2 - DW'(center_x_doubled)
                                           : DW'(center_x_doubled) - x2;
        dy = (y2 >= DW'(center_y_doubled)) ? y2 - DW'(center_y_doubled)
                                           : DW'(center_y_doubled) - y2;
    end

    assign dsq = (2*DW+1)'(sx_reg) + (2*DW+1)'(sy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv) begin
                v1_reg <= acc;
                v2_reg <= v1_reg;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= dx;
            dy_reg <= dy;
            p1_reg <= s_data.pred_bit;
            t1_reg <= s_data.truth_bit;
            e1_reg <= s_data.frame_end;
            sx_reg <= dx_reg * dx_reg;
            sy_reg <= dy_reg * dy_reg;
            p2_reg <= p1_reg;
            t2_reg <= t1_reg;
            e2_reg <= e1_reg;
        end
    end

    assign q_valid          = v2_reg;
    assign q_data.pred_bit  = p2_reg;
    assign q_data.truth_bit = t2_reg;
    assign q_data.frame_end = e2_reg;
    assign q_data.in_center = dsq < (2*DW+1)'(center_radius_sq);
    assign q_data.in_edge   = dsq > (2*DW+1)'(edge_radius_sq);

endmodule

// ===== rtl/srm_fifo.sv =====
// ----------------------------------------------------------------------------
// srm_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module srm_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                w_valid,
    output logic                w_ready,
    input  srm_pkg::pix_class_t w_data,
    output logic                r_valid,
    input  logic                r_ready,
    output srm_pkg::pix_class_t r_data
);
    srm_pkg::pix_class_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign w_ready = cnt_reg != 3'd4;
    assign r_valid = cnt_reg != 3'd0;
    assign wr      = w_valid && w_ready;
    assign rd      = r_valid && r_ready;
    assign r_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= w_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 3'd4 |-> !wr) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 3'd0 |-> !rd) else $error("queue underflow");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/srm_back.sv =====
// ----------------------------------------------------------------------------
// srm_back
// Counts per region and, at frame end, computes the three result beats
// with a shared bit-serial divider.
// ----------------------------------------------------------------------------
module srm_back #(
    parameter int FRAC_BITS = srm_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  srm_pkg::pix_class_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srm_pkg::out_beat_t  m_data
);
    localparam int CW  = srm_pkg::CNT_W;
    localparam int MW  = srm_pkg::MET_W;
    localparam int DNW = CW + 2;
    localparam int NW  = DNW + FRAC_BITS + 1;
    localparam int SW  = $clog2(NW + 1);

    localparam logic [1:0] ST_COUNT = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    srm_pkg::region_cnt_t cnt_reg [3];
    logic [1:0] st_reg;
    logic [1:0] rg_reg;
    logic [1:0] mi_reg;
    logic [SW-1:0] bit_reg;
    logic [NW-1:0] num_reg;
    logic [DNW:0]  rem_reg;
    logic [DNW-1:0] den_reg;
    logic [MW-1:0] met_reg [4];
    srm_pkg::out_beat_t ob_reg;
    logic ov_reg;

    logic take;
    srm_pkg::region_cnt_t cur;
    logic [DNW-1:0] sum3, tpfp, tpfn, f1d, tp2;
    logic [DNW-1:0] sel_num, sel_den;
    logic [DNW:0] trial;

    assign q_ready = (st_reg == ST_COUNT);
    assign take    = q_valid && q_ready;

    assign cur  = cnt_reg[rg_reg];
    assign tp2  = {1'b0, cur.tp, 1'b0};
    assign sum3 = DNW'(cur.tp) + DNW'(cur.fp) + DNW'(cur.fn);
    assign tpfp = DNW'(cur.tp) + DNW'(cur.fp);
    assign tpfn = DNW'(cur.tp) + DNW'(cur.fn);
    assign f1d  = tp2 + DNW'(cur.fp) + DNW'(cur.fn);

    // metric operand select
    always_comb begin
        sel_num = DNW'(cur.tp);
        case (mi_reg)
            2'd0: sel_den = sum3;
            2'd1: sel_den = tpfp;
            2'd2: sel_den = tpfn;
            default: begin
                sel_num = tp2;
                sel_den = f1d;
            end
        endcase
    end

    assign trial = {rem_reg[DNW-1:0], num_reg[NW-1]};

    // count update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) cnt_reg[r] <= '0;
        end else if (take) begin
            for (int r = 0; r < 3; r++) begin
                if (r == 0 || (r == 1 && q_data.in_center) || (r == 2 && q_data.in_edge))
                begin
                    if (q_data.pred_bit && q_data.truth_bit)
                        cnt_reg[r].tp <= srm_pkg::sat_inc(cnt_reg[r].tp);
                    else if (q_data.pred_bit)
                        cnt_reg[r].fp <= srm_pkg::sat_inc(cnt_reg[r].fp);
                    else if (q_data.truth_bit)
                        cnt_reg[r].fn <= srm_pkg::sat_inc(cnt_reg[r].fn);
                    cnt_reg[r].tot <= srm_pkg::sat_inc(cnt_reg[r].tot);
                end
            end
        end else if (st_reg == ST_OUT && !ov_reg && rg_reg == srm_pkg::REGION_EDGE
                     && mi_reg == 2'd0) begin
            for (int r = 0; r < 3; r++) cnt_reg[r] <= '0;
        end
    end

    // sequencer: one restoring divide per metric, one result beat per region
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_COUNT;
            rg_reg  <= '0;
            mi_reg  <= '0;
            bit_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (st_reg)
                ST_COUNT: begin
                    if (take && q_data.frame_end) begin
                        st_reg <= ST_SETUP;
                        rg_reg <= srm_pkg::REGION_FULL;
                        mi_reg <= '0;
                    end
                end
                ST_SETUP: begin
                    rem_reg <= '0;
                    den_reg <= sel_den;
                    bit_reg <= SW'(NW);
                    // half divisor rounding folded into numerator
                    num_reg <= (NW'(sel_num) << FRAC_BITS) + NW'(sel_den >> 1);
                    st_reg  <= ST_DIV;
                end
                ST_DIV: begin
                    if (bit_reg == '0) begin
                        met_reg[mi_reg] <= (den_reg == '0) ? '0 : num_reg[MW-1:0];
                        if (mi_reg == 2'd3) begin
                            st_reg <= ST_OUT;
                            mi_reg <= '0;
                        end else begin
                            mi_reg <= mi_reg + 2'd1;
                            st_reg <= ST_SETUP;
                        end
                    end else begin
                        if (trial >= {1'b0, den_reg}) begin
                            rem_reg <= trial - {1'b0, den_reg};
                            num_reg <= {num_reg[NW-2:0], 1'b1};
                        end else begin
                            rem_reg <= trial;
                            num_reg <= {num_reg[NW-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg - SW'(1);
                    end
                end
                ST_OUT: begin
                    if (!ov_reg) begin
                        ov_reg <= 1'b1;
                        ob_reg.region_id     <= rg_reg;
                        ob_reg.true_pos      <= cur.tp;
                        ob_reg.false_pos     <= cur.fp;
                        ob_reg.false_neg     <= cur.fn;
                        ob_reg.true_neg      <= (DNW'(cur.tot) >= sum3)
                                                ? CW'(DNW'(cur.tot) - sum3) : '0;
                        ob_reg.iou_q16       <= met_reg[0];
                        ob_reg.precision_q16 <= met_reg[1];
                        ob_reg.recall_q16    <= met_reg[2];
                        ob_reg.f1_q16        <= met_reg[3];
                        ob_reg.last_of_run   <= (rg_reg == srm_pkg::REGION_EDGE);
                        if (rg_reg == srm_pkg::REGION_EDGE) begin
                            st_reg <= ST_COUNT;
                            rg_reg <= '0;
                        end else begin
                            rg_reg <= rg_reg + 2'd1;
                            st_reg <= ST_SETUP;
                        end
                    end
                end
                default: st_reg <= ST_COUNT;
            endcase
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = ob_reg;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_COUNT |-> !take) else $error("pixel taken while computing");
    a_region_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rg_reg != 2'd3) else $error("region index out of range");
    a_last_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_of_run |-> m_data.region_id == srm_pkg::REGION_EDGE)
        else $error("last flag on wrong region");
`endif

endmodule

// ===== rtl/segmentation_region_metrics.sv =====
// ----------------------------------------------------------------------------
// segmentation_region_metrics
// Confusion-matrix counts and Q1.16 ratios over full, center and edge regions.
// ----------------------------------------------------------------------------
//  channel | ports            | beat
//  --------+------------------+------------------------------------------
//  input   | s_valid/s_ready  | one pixel: pred, truth, frame end
//  output  | m_valid/m_ready  | one region result, three per frame
//  config  | cfg_valid/ready  | register index and write data
//
//  pixels enter one per cycle, while s_ready is high, through a two-stage
//  distance pipeline; a frame end runs the serial divider for each region
//  (per metric a setup, 44 divide steps and a store, then the result load);
//  while a result beat waits, the pixel queue fills and s_ready drops
//  reset is synchronous, active low, and clears positions and counts
// ----------------------------------------------------------------------------
module segmentation_region_metrics #(
    parameter int MAX_WIDTH  = srm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = srm_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = srm_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srm_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output srm_pkg::out_beat_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic [12:0] fw_reg, cx_reg, cy_reg;
    logic [srm_pkg::SQ_W-1:0] crs_reg, ers_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    srm_pkg::pix_class_t f_data, b_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= 13'd640;
            cx_reg  <= 13'd640;
            cy_reg  <= 13'd480;
            crs_reg <= '0;
            ers_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                srm_pkg::REG_FRAME_WIDTH: fw_reg  <= cfg_data[12:0];
                srm_pkg::REG_CENTER_X:    cx_reg  <= cfg_data[12:0];
                srm_pkg::REG_CENTER_Y:    cy_reg  <= cfg_data[12:0];
                srm_pkg::REG_CENTER_RSQ:  crs_reg <= cfg_data[srm_pkg::SQ_W-1:0];
                srm_pkg::REG_EDGE_RSQ:    ers_reg <= cfg_data[srm_pkg::SQ_W-1:0];
                default: ;
            endcase
        end
    end

    srm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .frame_width(fw_reg), .center_x_doubled(cx_reg), .center_y_doubled(cy_reg),
        .center_radius_sq(crs_reg), .edge_radius_sq(ers_reg),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    srm_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
        .r_valid(b_valid), .r_ready(b_ready), .r_data(b_data)
    );

    srm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ===== bench/segmentation_region_metrics_tb.sv =====
// ----------------------------------------------------------------------------
// segmentation_region_metrics_tb
// Drives pixel frames under several region settings and checks every region
// result against a cycle-free model of the counts and Q1.16 ratios.
// ----------------------------------------------------------------------------
class region_metrics_board;
    int unsigned frame_width;
    int unsigned center_x2;
    int unsigned center_y2;
    longint unsigned center_rsq;
    longint unsigned edge_rsq;
    int unsigned col;
    int unsigned row;
    longint unsigned counts [12];
    srm_pkg::out_beat_t expected_q [$];
    int errors;

    function void clear_counts();
        for (int i = 0; i < 12; i++) counts[i] = 0;
        col = 0;
        row = 0;
    endfunction

    function void reset_state();
        frame_width = 640;
        center_x2 = 480 + 160;
        center_y2 = 480;
        center_rsq = 0;
        edge_rsq = 0;
        errors = 0;
        clear_counts();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            srm_pkg::REG_FRAME_WIDTH: frame_width = val[12:0];
            srm_pkg::REG_CENTER_X:    center_x2 = val[12:0];
            srm_pkg::REG_CENTER_Y:    center_y2 = val[12:0];
            srm_pkg::REG_CENTER_RSQ:  center_rsq = val[27:0];
            srm_pkg::REG_EDGE_RSQ:    edge_rsq = val[27:0];
            default: ;
        endcase
    endfunction

    function void bump(int idx);
        if (counts[idx] < 64'h1FFFFFF) counts[idx]++;
    endfunction

    function void tally(int region, bit p, bit t);
        if (p && t) bump(region * 4);
        else if (p) bump(region * 4 + 1);
        else if (t) bump(region * 4 + 2);
        bump(region * 4 + 3);
    endfunction

    function longint unsigned ratio_q16(longint unsigned num, longint unsigned den);
        if (den == 0) return 0;
        return (((num << 16) + (den >> 1)) / den) & 64'h1FFFF;
    endfunction

    // account one accepted pixel and queue the region results on frame end
    function void note_pixel(srm_pkg::in_beat_t px);
        longint unsigned dx, dy, dsq, w, tp, fp, fn, tot, sum;
        srm_pkg::out_beat_t r;
        dx = (col * 2 >= center_x2) ? col * 2 - center_x2 : center_x2 - col * 2;
        dy = (row * 2 >= center_y2) ? row * 2 - center_y2 : center_y2 - row * 2;
        dsq = dx * dx + dy * dy;
        w = frame_width;
        if (w == 0) w = 1;
        if (w > 4096) w = 4096;
        tally(0, px.pred_bit, px.truth_bit);
        if (dsq < center_rsq) tally(1, px.pred_bit, px.truth_bit);
        if (dsq > edge_rsq) tally(2, px.pred_bit, px.truth_bit);
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= 4096) ? 0 : row + 1;
        end else begin
            col++;
        end
        if (!px.frame_end) return;
        for (int g = 0; g < 3; g++) begin
            tp = counts[g * 4];
            fp = counts[g * 4 + 1];
            fn = counts[g * 4 + 2];
            tot = counts[g * 4 + 3];
            sum = tp + fp + fn;
            r.region_id = g[1:0];
            r.true_pos = tp[24:0];
            r.false_pos = fp[24:0];
            r.false_neg = fn[24:0];
            r.true_neg = (tot >= sum) ? 25'(tot - sum) : '0;
            r.iou_q16 = 17'(ratio_q16(tp, sum));
            r.precision_q16 = 17'(ratio_q16(tp, tp + fp));
            r.recall_q16 = 17'(ratio_q16(tp, tp + fn));
            r.f1_q16 = 17'(ratio_q16(2 * tp, 2 * tp + fp + fn));
            r.last_of_run = (g == 2);
            expected_q.insert(expected_q.size(), r);
        end
        clear_counts();
    endfunction

    function void check_result(srm_pkg::out_beat_t got);
        srm_pkg::out_beat_t e;
        if (expected_q.size() == 0) begin
            $error("unexpected result beat region %0d", got.region_id);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.region_id !== e.region_id) begin
            $error("region_id exp %0d got %0d", e.region_id, got.region_id); errors++;
        end
        if (got.true_pos !== e.true_pos) begin
            $error("true_pos exp %0d got %0d", e.true_pos, got.true_pos); errors++;
        end
        if (got.false_pos !== e.false_pos) begin
            $error("false_pos exp %0d got %0d", e.false_pos, got.false_pos); errors++;
        end
        if (got.false_neg !== e.false_neg) begin
            $error("false_neg exp %0d got %0d", e.false_neg, got.false_neg); errors++;
        end
        if (got.true_neg !== e.true_neg) begin
            $error("true_neg exp %0d got %0d", e.true_neg, got.true_neg); errors++;
        end
        if (got.iou_q16 !== e.iou_q16) begin
            $error("iou_q16 exp %0d got %0d", e.iou_q16, got.iou_q16); errors++;
        end
        if (got.precision_q16 !== e.precision_q16) begin
            $error("precision_q16 exp %0d got %0d", e.precision_q16, got.precision_q16);
            errors++;
        end
        if (got.recall_q16 !== e.recall_q16) begin
            $error("recall_q16 exp %0d got %0d", e.recall_q16, got.recall_q16); errors++;
        end
        if (got.f1_q16 !== e.f1_q16) begin
            $error("f1_q16 exp %0d got %0d", e.f1_q16, got.f1_q16); errors++;
        end
        if (got.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, got.last_of_run); errors++;
        end
    endfunction
endclass

module segmentation_region_metrics_tb;
    localparam longint CYCLE_LIMIT = 2000000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    srm_pkg::in_beat_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    srm_pkg::out_beat_t m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    region_metrics_board board;
    longint cycle_count = 0;
    bit quiet_tail = 0;
    bit hold_result = 0;
    bit run_done = 0;

    segmentation_region_metrics u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // cycle limit guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segmentation_region_metrics_tb: FAIL");
            $finish;
        end
    end

    // result sampling and checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // receiver: random stall bursts, one long hold-off when asked
    initial begin : result_sink
        int n;
        board = new();
        board.reset_state();
        forever begin
            @(negedge aclk);
            if (hold_result) begin
                m_ready <= 1'b0;
                for (int i = 0; i < 600; i++) @(negedge aclk);
                hold_result = 0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                m_ready <= 1'b0;
                for (int i = 1; i < n; i++) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // valid stays up after an accepted beat until the next call or drain
    task automatic send_pixel(bit p, bit t, bit last);
        srm_pkg::in_beat_t b;
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        b.pred_bit = p;
        b.truth_bit = t;
        b.frame_end = last;
        s_data <= b;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pixel(b);
        @(negedge aclk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // idle point: all results back plus divider latency for trailing pixels
    task automatic drain();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
    endtask

    task automatic set_regions(int w, int cx, int cy, int crsq, int ersq);
        write_cfg(srm_pkg::REG_FRAME_WIDTH, w);
        write_cfg(srm_pkg::REG_CENTER_X, cx);
        write_cfg(srm_pkg::REG_CENTER_Y, cy);
        write_cfg(srm_pkg::REG_CENTER_RSQ, crsq);
        write_cfg(srm_pkg::REG_EDGE_RSQ, ersq);
        cfg_valid <= 1'b0;
    endtask

    // a frame of random pixels; a random mode sets how often masks agree
    task automatic random_frame(int len);
        int mode;
        bit p, t;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            p = $urandom_range(0, 1);
            case (mode)
                0: t = p;
                1: t = !p;
                default: t = $urandom_range(0, 1);
            endcase
            send_pixel(p, t, i == len - 1);
        end
    endtask

    initial begin : stimulus
        int sent;
        int len;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: reset settings, all four pixel classes, single-pixel frame
        send_pixel(1, 1, 0);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 0);
        send_pixel(0, 0, 1);
        send_pixel(0, 0, 1);
        drain();
        // width zero acts as one, center covers a column, edge wide open
        set_regions(0, 0, 4, 20, 0);
        send_pixel(1, 1, 0);
        send_pixel(1, 1, 0);
        send_pixel(0, 1, 0);
        send_pixel(1, 0, 0);
        send_pixel(1, 1, 1);
        drain();
        // extreme register values, empty center gives zeros
        set_regions(8191, 8191, 8191, 0, 28'hFFFFFFF);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 0);
        send_pixel(1, 1, 1);
        drain();
        set_regions(4096, 8191, 0, 28'hFFFFFFF, 0);
        send_pixel(0, 0, 0);
        send_pixel(1, 1, 0);
        send_pixel(1, 1, 1);
        drain();
        // a frame of three pixels across one row of width three
        set_regions(3, 2, 2, 5, 3);
        send_pixel(1, 1, 0);
        send_pixel(0, 1, 0);
        send_pixel(1, 0, 1);
        drain();

        // receiver holds off while frames keep coming
        hold_result = 1;
        for (int k = 0; k < 4; k++) random_frame(5);
        drain();

        // random frames over several region settings
        sent = 0;
        while (sent < 360) begin
            set_regions($urandom_range(1, 9), $urandom_range(0, 20), $urandom_range(0, 16),
                        $urandom_range(0, 80), $urandom_range(0, 80));
            for (int k = 0; k < 4 && sent < 360; k++) begin
                len = $urandom_range(1, 24);
                if (sent > 300) quiet_tail = 1;
                random_frame(len);
                sent += len;
            end
            drain();
        end
        // trailing pixels with no frame end
        send_pixel(1, 1, 0);
        send_pixel(0, 1, 0);
        drain();

        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("segmentation_region_metrics_tb: PASS");
        end else begin
            $display("segmentation_region_metrics_tb: FAIL");
        end
        $finish;
    end
endmodule
